// ===== rtl/pvsc_pkg.sv =====
// ----------------------------------------------------------------------------
// pvsc_pkg
// Types and constants shared by the pileup variant support counter.
// ----------------------------------------------------------------------------
package pvsc_pkg;

	localparam int POSITIONS = 65536;
	localparam int MAX_READS = 1024;

	localparam int POS_AW = $clog2(POSITIONS);
	localparam int POS_CW = $clog2(POSITIONS + 1);
	localparam int IW     = (POS_CW > 17) ? POS_CW : 17;
	localparam int QA_W   = $clog2(MAX_READS);
	localparam int RIDX_W = $clog2(MAX_READS + 1);

	// request codes
	localparam logic [2:0] REQ_QUAL   = 3'd0;
	localparam logic [2:0] REQ_BASE   = 3'd1;
	localparam logic [2:0] REQ_COLEND = 3'd2;
	localparam logic [2:0] REQ_QUERY  = 3'd3;
	localparam logic [2:0] REQ_CLEAR  = 3'd4;

	typedef enum logic [1:0] {
		REG_QUAL_THRESHOLD = 2'd0,
		REG_QUAL_OFFSET    = 2'd1,
		REG_MIN_SUPPORT    = 2'd2
	} cfg_reg_t;

	localparam logic [6:0] QUAL_THRESHOLD_RST = 7'd20;
	localparam logic [6:0] QUAL_OFFSET_RST    = 7'd33;
	localparam logic [7:0] MIN_SUPPORT_RST    = 8'd2;

	// base-string characters
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  char_value;
		logic [16:0] position;
		logic [16:0] interval_start;
		logic [16:0] interval_end;
	} req_t;

	typedef struct packed {
		logic [25:0] interval_sum;
		logic        clipped;
	} rsp_t;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_BASE = 6'b000010,
		ST_COL  = 6'b000100,
		ST_QRY  = 6'b001000,
		ST_DONE = 6'b010000,
		ST_CLR  = 6'b100000
	} state_t;

	typedef enum logic [3:0] {
		PM_NORMAL = 4'b0001,
		PM_CARET  = 4'b0010,
		PM_DIGITS = 4'b0100,
		PM_SKIP   = 4'b1000
	} pmode_t;

endpackage

// ===== rtl/pileup_variant_support_counter_unit.sv =====
// ----------------------------------------------------------------------------
// pileup_variant_support_counter_unit
// Parses pileup base strings one character a beat, counts high-quality
// A/C/G/T mismatches per column and keeps per-position support counters in
// a RAM (four packed 8-bit wrapping counters per position, A in the low byte).
// Steps: a quality character is stored in the quality RAM; a base character
// goes through the quality RAM read and then the parser step; a column end
// does a read-modify-write of the support RAM; an interval query walks the
// clipped interval (no read when it is empty or reversed), one support RAM
// read a cycle, then waits for the result register to drain; a clear writes
// one RAM word a cycle. A clearing pass over all 65536 words runs after
// reset, and no beat is accepted meanwhile (configuration writes are taken at any time).
// ----------------------------------------------------------------------------
module pileup_variant_support_counter_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  pvsc_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output pvsc_pkg::rsp_t      rsp,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import pvsc_pkg::*;

	// configuration
	logic [6:0] qthr_q;
	logic [6:0] qofs_q;
	logic [7:0] minsup_q;

	state_t             st_q;
	pmode_t             mode_q, mode_d;
	logic [15:0]        skip_q, skip_d;
	logic [15:0]        len_q, len_d;
	logic [RIDX_W-1:0]  ridx_q, ridx_d, ridx_inc;
	logic [RIDX_W-1:0]  fill_q;
	logic [7:0]         hits_q [4];
	logic [7:0]         hits_d [4];

	logic [7:0]         qmem [MAX_READS];
	logic [7:0]         qdata_s1;
	logic [7:0]         char_s1;

	logic [31:0]        smem [POSITIONS];
	logic [31:0]        s_rdata;
	logic               s_re, s_we;
	logic [POS_AW-1:0]  s_raddr;
	logic [31:0]        s_wdata;

	logic [POS_CW-1:0]  addr_q, end_q;
	logic               pos_ok_s1;
	logic               rd_pend_q;
	logic [25:0]        acc_q;
	logic               clip_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic               rsp_load;

	logic               accept;
	logic               pos_ok;
	logic [16:0]        pos_m1;
	logic [IW-1:0]      s_ext, e_ext, e_clip;
	logic               q_over, q_empty;
	logic               digit;
	logic [19:0]        len_x10;
	logic               do_norm;
	logic [1:0]         bcode;
	logic               bvalid;
	logic               qual_ok;
	logic [9:0]         word_sum;
	logic [31:0]        col_word;

	assign req_ready = (st_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (st_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	// request decode
	assign pos_m1  = req.position - 17'd1;
	assign pos_ok  = (req.position != 17'd0) && (IW'(req.position) <= IW'(POSITIONS));
	assign s_ext   = IW'(req.interval_start);
	assign e_ext   = IW'(req.interval_end);
	assign q_over  = e_ext > IW'(POSITIONS);
	assign e_clip  = q_over ? IW'(POSITIONS) : e_ext;
	assign q_empty = e_clip <= s_ext;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qthr_q   <= QUAL_THRESHOLD_RST;
			qofs_q   <= QUAL_OFFSET_RST;
			minsup_q <= MIN_SUPPORT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_QUAL_THRESHOLD: qthr_q   <= cfg_data[6:0];
				REG_QUAL_OFFSET:    qofs_q   <= cfg_data[6:0];
				REG_MIN_SUPPORT:    minsup_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// quality RAM
	always_ff @(posedge clk) begin
		if (accept && req.req_type == REQ_QUAL && fill_q < RIDX_W'(MAX_READS))
			qmem[fill_q[QA_W-1:0]] <= req.char_value;
		if (accept && req.req_type == REQ_BASE)
			qdata_s1 <= qmem[ridx_q[QA_W-1:0]];
		if (accept)
			char_s1 <= req.char_value;
	end

	// base-string parser, evaluated in ST_BASE
	always_comb begin
		unique case (char_s1)
			8'h41, 8'h61: begin bcode = 2'd0; bvalid = 1'b1; end
			8'h43, 8'h63: begin bcode = 2'd1; bvalid = 1'b1; end
			8'h47, 8'h67: begin bcode = 2'd2; bvalid = 1'b1; end
			8'h54, 8'h74: begin bcode = 2'd3; bvalid = 1'b1; end
			default:      begin bcode = 2'd0; bvalid = 1'b0; end
		endcase
	end

	assign digit    = (char_s1 >= CH_ZERO) && (char_s1 <= CH_NINE);
	assign len_x10  = {1'b0, len_q, 3'b000} + {3'b000, len_q, 1'b0}
		+ {16'd0, char_s1[3:0]};
	assign ridx_inc = (ridx_q < RIDX_W'(MAX_READS)) ? ridx_q + RIDX_W'(1) : ridx_q;
	// score >= threshold, with a negative score never passing
	assign qual_ok  = {2'b00, qdata_s1} >= ({3'b000, qofs_q} + {3'b000, qthr_q});

	always_comb begin
		mode_d  = mode_q;
		skip_d  = skip_q;
		len_d   = len_q;
		ridx_d  = ridx_q;
		hits_d  = hits_q;
		do_norm = 1'b0;
		unique case (mode_q)
			PM_CARET: mode_d = PM_NORMAL;
			PM_DIGITS: begin
				if (digit) begin
					len_d = (len_x10 > 20'hFFFF) ? 16'hFFFF : len_x10[15:0];
				end else if (len_q == 16'd0) begin
					do_norm = 1'b1;
				end else begin
					skip_d = len_q - 16'd1;
					len_d  = 16'd0;
					mode_d = (len_q == 16'd1) ? PM_NORMAL : PM_SKIP;
				end
			end
			PM_SKIP: begin
				if (skip_q != 16'd0)
					skip_d = skip_q - 16'd1;
				if (skip_q <= 16'd1)
					mode_d = PM_NORMAL;
			end
			default: do_norm = 1'b1;
		endcase
		if (do_norm) begin
			mode_d = PM_NORMAL;
			priority if (char_s1 == CH_DOT || char_s1 == CH_COMMA) begin
				ridx_d = ridx_inc;
			end else if (char_s1 == CH_DOLLAR) begin
				ridx_d = ridx_q;
			end else if (char_s1 == CH_CARET) begin
				mode_d = PM_CARET;
			end else if (char_s1 == CH_PLUS || char_s1 == CH_MINUS) begin
				mode_d = PM_DIGITS;
				len_d  = 16'd0;
			end else begin
				if (bvalid && ridx_q < fill_q && qual_ok && hits_q[bcode] != 8'hFF)
					hits_d[bcode] = hits_q[bcode] + 8'd1;
				ridx_d = ridx_inc;
			end
		end
	end

	// support RAM ports
	always_comb begin
		word_sum = 10'(s_rdata[7:0]) + 10'(s_rdata[15:8])
			+ 10'(s_rdata[23:16]) + 10'(s_rdata[31:24]);
		for (int k = 0; k < 4; k++) begin
			col_word[8*k +: 8] = (hits_q[k] >= minsup_q) ? s_rdata[8*k +: 8] + 8'd1
				: s_rdata[8*k +: 8];
		end
	end

	assign s_re    = (accept && req.req_type == REQ_COLEND && pos_ok)
		|| (st_q == ST_QRY && addr_q != end_q);
	assign s_raddr = (st_q == ST_QRY) ? addr_q[POS_AW-1:0] : pos_m1[POS_AW-1:0];
	assign s_we    = (st_q == ST_COL && pos_ok_s1) || (st_q == ST_CLR);
	assign s_wdata = (st_q == ST_CLR) ? 32'd0 : col_word;

	always_ff @(posedge clk) begin
		if (s_we)
			smem[addr_q[POS_AW-1:0]] <= s_wdata;
		if (s_re)
			s_rdata <= smem[s_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			mode_q      <= PM_NORMAL;
			skip_q      <= '0;
			len_q       <= '0;
			ridx_q      <= '0;
			fill_q      <= '0;
			hits_q      <= '{default: '0};
			addr_q      <= '0;
			end_q       <= '0;
			pos_ok_s1   <= 1'b0;
			rd_pend_q   <= 1'b0;
			acc_q       <= '0;
			clip_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.req_type)
							REQ_QUAL: begin
								if (fill_q < RIDX_W'(MAX_READS))
									fill_q <= fill_q + RIDX_W'(1);
							end
							REQ_BASE: st_q <= ST_BASE;
							REQ_COLEND: begin
								st_q      <= ST_COL;
								pos_ok_s1 <= pos_ok;
								addr_q    <= POS_CW'(pos_m1);
							end
							REQ_QUERY: begin
								st_q      <= ST_QRY;
								end_q     <= POS_CW'(e_clip);
								addr_q    <= q_empty ? POS_CW'(e_clip) : POS_CW'(s_ext);
								clip_q    <= q_over || q_empty;
								acc_q     <= '0;
								rd_pend_q <= 1'b0;
							end
							REQ_CLEAR: begin
								st_q   <= ST_CLR;
								addr_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_BASE: begin
					mode_q <= mode_d;
					skip_q <= skip_d;
					len_q  <= len_d;
					ridx_q <= ridx_d;
					hits_q <= hits_d;
					st_q   <= ST_IDLE;
				end
				ST_COL: begin
					// column done: parser back to its starting state
					mode_q <= PM_NORMAL;
					skip_q <= '0;
					len_q  <= '0;
					ridx_q <= '0;
					fill_q <= '0;
					hits_q <= '{default: '0};
					st_q   <= ST_IDLE;
				end
				ST_QRY: begin
					if (addr_q != end_q)
						addr_q <= addr_q + POS_CW'(1);
					rd_pend_q <= (addr_q != end_q);
					if (rd_pend_q)
						acc_q <= acc_q + 26'(word_sum);
					if (addr_q == end_q && !rd_pend_q)
						st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (rsp_load)
						st_q <= ST_IDLE;
				end
				ST_CLR: begin
					addr_q <= addr_q + POS_CW'(1);
					if (addr_q == POS_CW'(POSITIONS - 1))
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.interval_sum <= acc_q;
			rsp_q.clipped      <= clip_q;
		end
	end

	// checks
	a_query_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_QUERY |=> st_q == ST_QRY)
		else $error("query beat did not start the interval walk");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_QRY |-> addr_q <= end_q)
		else $error("interval walk ran past its end");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DONE && (!rsp_valid || rsp_ready) |=> rsp_valid && st_q == ST_IDLE)
		else $error("finished query did not produce a result beat");

endmodule

// ===== tb/pileup_variant_support_counter_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pileup_variant_support_counter_unit_test
// Self-checking bench: drives quality/base-string/column-end/query/clear beats
// with random handshake gaps, tracks parse state and per-position support
// counters in a local shadow, and checks every interval query result in order.
// ----------------------------------------------------------------------------
module pileup_variant_support_counter_unit_test;
	import pvsc_pkg::*;

	localparam int HOLD_CYCLES = 300;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;
	logic  cfg_we = 1'b0;
	logic  [1:0] cfg_index = '0;
	logic  [7:0] cfg_data = '0;

	pileup_variant_support_counter_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// shadow of the block
	bit [6:0]        q_thresh = QUAL_THRESHOLD_RST;
	bit [6:0]        q_offset = QUAL_OFFSET_RST;
	bit [7:0]        min_sup = MIN_SUPPORT_RST;
	pmode_t          pm = PM_NORMAL;
	bit [15:0]       skip_cnt;
	bit [15:0]       indel_len;
	bit [RIDX_W-1:0] read_idx;
	bit [RIDX_W-1:0] qual_fill;
	bit [7:0]        qual_mem [MAX_READS];
	bit [7:0]        hits [4];
	bit [31:0]       counts [POSITIONS];

	rsp_t sums_due [$];
	int   mismatches = 0;
	int   beats_done = 0;
	int   tx_idle_pct = 0;
	int   rx_stall_pct = 0;
	int   hold_asks = 0;
	int   hold_taken = 0;
	int   rx_hold_left = 0;

	typedef struct {
		logic [2:0] kind;
		string      text;
		int         reps;
		int         a;
		int         b;
		bit         typed;
		rsp_t       want;
	} plan_row_t;

	plan_row_t plan [$];

	function automatic int letter_slot(input bit [7:0] c);
		case (c)
			"A", "a": return 0;
			"C", "c": return 1;
			"G", "g": return 2;
			"T", "t": return 3;
			default: return -1;
		endcase
	endfunction

	function automatic void end_column();
		pm = PM_NORMAL;
		skip_cnt = '0;
		indel_len = '0;
		read_idx = '0;
		qual_fill = '0;
		foreach (hits[k]) hits[k] = '0;
	endfunction

	function automatic void read_char(input bit [7:0] c);
		int slot;
		int score;
		if (c == CH_DOT || c == CH_COMMA) begin
			if (read_idx < MAX_READS) read_idx++;
		end else if (c == CH_DOLLAR) begin
		end else if (c == CH_CARET) begin
			pm = PM_CARET;
		end else if (c == CH_PLUS || c == CH_MINUS) begin
			pm = PM_DIGITS;
			indel_len = '0;
		end else begin
			slot = letter_slot(c);
			// quality only exists for reads delivered this column
			if (slot >= 0 && read_idx < qual_fill) begin
				score = int'(qual_mem[read_idx]) - int'(q_offset);
				if (score >= int'(q_thresh) && hits[slot] != 8'hFF) hits[slot]++;
			end
			if (read_idx < MAX_READS) read_idx++;
		end
	endfunction

	function automatic void parse_char(input bit [7:0] c);
		int n;
		case (pm)
			PM_CARET: pm = PM_NORMAL;
			PM_DIGITS: begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					n = int'(indel_len) * 10 + int'(c - CH_ZERO);
					if (n > 65535) n = 65535;
					indel_len = 16'(n);
				end else if (indel_len == 0) begin
					pm = PM_NORMAL;
					read_char(c);
				end else begin
					// this char is the first inserted/deleted base
					skip_cnt = indel_len - 16'd1;
					indel_len = '0;
					pm = (skip_cnt != 0) ? PM_SKIP : PM_NORMAL;
				end
			end
			PM_SKIP: begin
				if (skip_cnt > 0) skip_cnt--;
				if (skip_cnt == 0) pm = PM_NORMAL;
			end
			default: begin
				pm = PM_NORMAL;
				read_char(c);
			end
		endcase
	endfunction

	// returns 1 when the beat produces a query result
	function automatic bit track_pileup(input req_t b, output rsp_t r);
		int s;
		int e;
		bit clip;
		bit [31:0] total;
		r = '0;
		case (b.req_type)
			REQ_QUAL: begin
				if (qual_fill < MAX_READS) begin
					qual_mem[qual_fill] = b.char_value;
					qual_fill++;
				end
			end
			REQ_BASE: parse_char(b.char_value);
			REQ_COLEND: begin
				if (b.position >= 1 && b.position <= POSITIONS) begin
					for (int k = 0; k < 4; k++)
						if (hits[k] >= min_sup) counts[b.position - 1][8*k +: 8] += 8'd1;
				end
				end_column();
			end
			REQ_QUERY: begin
				s = int'(b.interval_start);
				e = int'(b.interval_end);
				clip = 1'b0;
				total = '0;
				if (e > POSITIONS) begin
					e = POSITIONS;
					clip = 1'b1;
				end
				if (e <= s) begin
					clip = 1'b1;
				end else begin
					for (int i = s; i < e; i++)
						total += counts[i][7:0] + counts[i][15:8] + counts[i][23:16]
							+ counts[i][31:24];
				end
				r.interval_sum = total[25:0];
				r.clipped = clip;
				return 1'b1;
			end
			REQ_CLEAR: foreach (counts[i]) counts[i] = '0;
			default: ;
		endcase
		return 1'b0;
	endfunction

	function automatic req_t rand_beat(input logic [2:0] kind);
		req_t b;
		b.req_type = kind;
		b.char_value = 8'($urandom);
		b.position = 17'($urandom);
		b.interval_start = 17'($urandom);
		b.interval_end = 17'($urandom);
		return b;
	endfunction

	function automatic req_t pick_query();
		req_t b;
		int k;
		logic [16:0] x;
		logic [16:0] y;
		b = rand_beat(REQ_QUERY);
		k = $urandom_range(0, 99);
		if (k < 70) begin
			b.interval_start = 17'($urandom_range(0, 170));
			b.interval_end = b.interval_start + 17'($urandom_range(0, 40));
		end else if (k < 80) begin
			// reversed or empty: no walk
			x = 17'($urandom);
			y = 17'($urandom);
			b.interval_start = (x > y) ? x : y;
			b.interval_end = (x > y) ? y : x;
		end else if (k < 90) begin
			b.interval_start = 17'($urandom_range(65500, 131071));
		end else begin
			b.interval_start = 17'($urandom_range(65400, 65535));
			b.interval_end = b.interval_start + 17'($urandom_range(0, 200));
		end
		return b;
	endfunction

	function automatic logic [16:0] pick_position();
		int k;
		k = $urandom_range(0, 99);
		if (k < 85) return 17'($urandom_range(1, 160));
		if (k < 90) return '0;
		if (k < 95) return 17'($urandom_range(65530, 65536));
		return 17'($urandom);
	endfunction

	task automatic offer(input req_t b, input bit typed = 1'b0, input rsp_t want = '0);
		rsp_t r;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req <= b;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
		if (track_pileup(b, r)) sums_due.push_back(typed ? want : r);
		if (b.req_type <= REQ_CLEAR) beats_done++;
	endtask

	task automatic offer_char(input logic [2:0] kind, input bit [7:0] c);
		req_t b;
		b = rand_beat(kind);
		b.char_value = c;
		offer(b);
	endtask

	task automatic send_queries(input int n);
		repeat (n) offer(pick_query());
	endtask

	task automatic send_noise();
		req_t b;
		logic [2:0] kind;
		repeat ($urandom_range(1, 6)) begin
			kind = 3'($urandom_range(0, 7));
			if (kind == REQ_QUERY) begin
				b = pick_query();
			end else begin
				if (kind == REQ_CLEAR) kind = 3'($urandom_range(5, 7));
				b = rand_beat(kind);
				if (kind == REQ_COLEND) b.position = pick_position();
			end
			offer(b);
		end
	endtask

	// well-formed column: qualities, then reads with marks and indels, then column end
	task automatic send_column();
		string letters;
		string filler;
		int nreads;
		int nqual;
		int v;
		int len;
		bit [7:0] alt;
		req_t b;
		letters = "ACGTacgt";
		filler = "ACGTNacgtn*";
		nreads = $urandom_range(0, 10);
		nqual = ($urandom_range(0, 99) < 80) ? nreads : $urandom_range(0, 12);
		alt = letters[$urandom_range(0, 7)];
		repeat (nqual) begin
			if ($urandom_range(0, 99) < 85) begin
				v = int'(q_offset) + $urandom_range(0, 100);
				if (v > 255) v = 255;
			end else begin
				v = $urandom_range(0, 255);
			end
			offer_char(REQ_QUAL, 8'(v));
		end
		repeat (nreads) begin
			if ($urandom_range(0, 99) < 20) begin
				offer_char(REQ_BASE, CH_CARET);
				offer_char(REQ_BASE, 8'($urandom));
			end
			v = $urandom_range(0, 99);
			if (v < 30)
				offer_char(REQ_BASE, ($urandom_range(0, 1) != 0) ? CH_DOT : CH_COMMA);
			else if (v < 60)
				offer_char(REQ_BASE, ($urandom_range(0, 1) != 0) ? alt : alt ^ 8'h20);
			else if (v < 85)
				offer_char(REQ_BASE, letters[$urandom_range(0, 7)]);
			else
				offer_char(REQ_BASE, 8'($urandom));
			if ($urandom_range(0, 99) < 15) begin
				offer_char(REQ_BASE, ($urandom_range(0, 1) != 0) ? CH_PLUS : CH_MINUS);
				v = $urandom_range(0, 9);
				len = (v < 8) ? $urandom_range(1, 9) : (v < 9) ? $urandom_range(10, 20) : 0;
				if (len >= 10) offer_char(REQ_BASE, CH_ZERO + 8'(len / 10));
				offer_char(REQ_BASE, CH_ZERO + 8'(len % 10));
				repeat (len) offer_char(REQ_BASE, filler[$urandom_range(0, 10)]);
			end
			if ($urandom_range(0, 99) < 15) offer_char(REQ_BASE, CH_DOLLAR);
		end
		b = rand_beat(REQ_COLEND);
		b.position = pick_position();
		offer(b);
	endtask

	// empty query flushes everything in flight; then a few spare cycles
	task automatic settle();
		req_t b;
		b = rand_beat(REQ_QUERY);
		b.interval_start = '0;
		b.interval_end = '0;
		offer(b);
		req_valid <= 1'b0;
		while (sums_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_regs(input bit [7:0] thr, input bit [7:0] off, input bit [7:0] ms);
		cfg_we <= 1'b1;
		cfg_index <= REG_QUAL_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_QUAL_OFFSET;
		cfg_data <= off;
		@(posedge clk);
		cfg_index <= REG_MIN_SUPPORT;
		cfg_data <= ms;
		@(posedge clk);
		cfg_we <= 1'b0;
		q_thresh = thr[6:0];
		q_offset = off[6:0];
		min_sup = ms;
	endtask

	task automatic add_row(input logic [2:0] kind, input string text, input int reps,
			input int a = 0, input int b = 0, input bit typed = 1'b0,
			input int total = 0, input bit clip = 1'b0);
		plan_row_t row;
		row.kind = kind;
		row.text = text;
		row.reps = reps;
		row.a = a;
		row.b = b;
		row.typed = typed;
		row.want.interval_sum = 26'(total);
		row.want.clipped = clip;
		plan.push_back(row);
	endtask

	always @(posedge clk) begin
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			rsp_ready <= 1'b0;
		end else if (hold_taken != hold_asks) begin
			hold_taken = hold_asks;
			rx_hold_left = HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : sum_check
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (sums_due.size() == 0) begin
				$display("%0t: unexpected result sum %0d clipped %0b", $time,
					rsp.interval_sum, rsp.clipped);
				mismatches++;
			end else begin
				want = sums_due.pop_front();
				if (rsp.interval_sum !== want.interval_sum) begin
					$display("%0t: interval_sum expected %0d got %0d", $time,
						want.interval_sum, rsp.interval_sum);
					mismatches++;
				end
				if (rsp.clipped !== want.clipped) begin
					$display("%0t: clipped expected %0b got %0b", $time,
						want.clipped, rsp.clipped);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#16000000;
		$display("pileup_variant_support_counter_unit_test: FAIL");
		$finish;
	end

	initial begin : stimulus
		req_t b;
		int goal;
		int k;
		int clears_left;
		clears_left = 3;
		end_column();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		add_row(REQ_QUERY, "", 1, 0, 16, 1'b1, 0, 1'b0);
		add_row(REQ_QUERY, "", 1, 5, 5, 1'b1, 0, 1'b1);
		add_row(REQ_QUERY, "", 1, 9, 3, 1'b1, 0, 1'b1);
		// idx 3 scores zero, idx 4 scores below zero
		add_row(REQ_QUAL, "III! ", 1);
		add_row(REQ_BASE, "Aa^~$A+12GGGGGGGGGGGGCTG,-x+0A+999999q", 1);
		add_row(REQ_COLEND, "", 1, 1);
		add_row(REQ_QUERY, "", 1, 0, 1, 1'b1, 1, 1'b0);
		// quality overflow, hit saturation and read index saturation
		add_row(REQ_QUAL, "I", 1030);
		add_row(REQ_BASE, "g", 1030);
		add_row(REQ_BASE, "t", 4);
		add_row(REQ_COLEND, "", 1, 2);
		add_row(REQ_QUERY, "", 1, 1, 2, 1'b1, 1, 1'b0);
		add_row(REQ_QUAL, "II", 1);
		add_row(REQ_BASE, "AA", 1);
		add_row(REQ_COLEND, "", 1, POSITIONS);
		add_row(REQ_QUERY, "", 1, POSITIONS - 1, POSITIONS, 1'b1, 1, 1'b0);
		add_row(REQ_QUAL, "II", 1);
		add_row(REQ_BASE, "CC", 1);
		add_row(REQ_COLEND, "", 1, POSITIONS + 1);
		add_row(REQ_COLEND, "", 1, 0);
		add_row(REQ_QUERY, "", 1, POSITIONS - 1, 131071, 1'b1, 1, 1'b1);
		add_row(3'd5, "", 1);
		add_row(3'd7, "", 1);
		add_row(REQ_QUERY, "", 1, 0, POSITIONS);
		add_row(REQ_CLEAR, "", 1);
		add_row(REQ_QUERY, "", 1, 0, 16, 1'b1, 0, 1'b0);
		add_row(REQ_QUERY, "", 1, POSITIONS - 6, POSITIONS, 1'b1, 0, 1'b0);

		foreach (plan[i]) begin
			repeat (plan[i].reps) begin
				if (plan[i].text.len() != 0) begin
					for (int j = 0; j < plan[i].text.len(); j++)
						offer_char(plan[i].kind, plan[i].text[j]);
				end else begin
					b = rand_beat(plan[i].kind);
					b.position = 17'(plan[i].a);
					b.interval_start = 17'(plan[i].a);
					b.interval_end = 17'(plan[i].b);
					offer(b, plan[i].typed, plan[i].want);
				end
			end
		end

		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: program_regs(8'd20, 8'd33, 8'd1);
				1: program_regs(8'd0, 8'd0, 8'd2);
				2: program_regs(8'd93, 8'd64, 8'd1);
				3: program_regs(8'd127, 8'd127, 8'd0);
				4: program_regs(8'd10, 8'd33, 8'd255);
				7: program_regs(8'd30, 8'd48, 8'd3);
				default: program_regs(8'($urandom_range(0, 93)), 8'($urandom_range(0, 64)),
					8'($urandom_range(1, 4)));
			endcase
			tx_idle_pct = (p % 4 == 1) ? 64 : (p % 4 == 3) ? 23 : 0;
			rx_stall_pct = (p % 4 == 2) ? 64 : (p % 4 == 3) ? 23 : 0;
			if (p == 2) begin
				// long receiver hold while queries keep coming: input must back up
				hold_asks++;
				send_queries(12);
			end
			goal = beats_done + 50;
			while (beats_done < goal) begin
				k = $urandom_range(0, 99);
				if (k < 2 && clears_left > 0) begin
					offer(rand_beat(REQ_CLEAR));
					clears_left--;
				end else if (k < 70) begin
					send_column();
				end else if (k < 85) begin
					send_queries($urandom_range(1, 4));
				end else begin
					send_noise();
				end
			end
		end
		req_valid <= 1'b0;

		while (sums_due.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("pileup_variant_support_counter_unit_test: PASS");
		else
			$display("pileup_variant_support_counter_unit_test: FAIL");
		$finish;
	end

endmodule
